### rtl/fdg_pkg.sv
`timescale 1ns / 1ps

package fdg_pkg;

	// window and arithmetic widths
	localparam int MAX_WINDOW = 16;
	localparam int FLOW_W     = 16;
	localparam int MAG_W      = 16;
	localparam int FRAME_W    = 28;
	localparam int TOTAL_W    = 32;
	localparam int NUM_DIR    = 4;
	localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

	// direction lanes
	localparam int DIR_UP    = 0;
	localparam int DIR_DOWN  = 1;
	localparam int DIR_LEFT  = 2;
	localparam int DIR_RIGHT = 3;

	// window adder tree: groups of four entries, then a sum over the groups
	localparam int GROUP    = 4;
	localparam int N_GROUPS = (MAX_WINDOW + GROUP - 1) / GROUP;
	localparam int PART_W   = FRAME_W + 2;
	localparam int GSUM_W   = $clog2(N_GROUPS) + 1;
	localparam int FULL_W   = (PART_W + GSUM_W > TOTAL_W) ? PART_W + GSUM_W : TOTAL_W + 1;

	// threshold: 3 pixels per frame per area unit, flow in 1/16 pixel
	localparam int WIN_CFG_W  = 5;
	localparam int AREA_W     = 12;
	localparam int THR_SCALE  = 48;
	localparam int THR_W      = 6 + CNT_W + AREA_W;

	// configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_WINDOW = 1'b0;
	localparam logic REG_AREA   = 1'b1;
	localparam logic [WIN_CFG_W-1:0] WINDOW_RESET = 5'd8;
	localparam logic [AREA_W-1:0]    AREA_RESET   = 12'd76;

	typedef struct packed {
		logic signed [FLOW_W-1:0] flow_dx;
		logic signed [FLOW_W-1:0] flow_dy;
		logic                     frame_end;
	} sample_t;

	typedef struct packed {
		logic               waving;
		logic [TOTAL_W-1:0] up_total;
		logic [TOTAL_W-1:0] down_total;
		logic [TOTAL_W-1:0] left_total;
		logic [TOTAL_W-1:0] right_total;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0] win;
		logic [THR_W-1:0] thr;
	} cfg_t;

	typedef logic [NUM_DIR-1:0][FRAME_W-1:0]                  dir_frame_t;
	typedef logic [MAX_WINDOW-1:0][NUM_DIR-1:0][FRAME_W-1:0]  history_t;
	typedef logic [NUM_DIR-1:0][N_GROUPS-1:0][PART_W-1:0]     dir_part_t;
	typedef logic [NUM_DIR-1:0][TOTAL_W-1:0]                  dir_total_t;

endpackage

### rtl/flow_direction_gesture_detector_unit.sv
`timescale 1ns / 1ps
// channel   direction  handshake                 payload
// sample    in         sample_valid/sample_stall sample_t: flow_dx, flow_dy, frame_end
// result    out        result_valid/result_stall result_t: waving, up/down/left/right totals
// config    in         apb psel/penable/pwrite   window_frames @0x0, region_area @0x4
//
// one sample beat per cycle sustained while sample_stall stays low; a frame-end beat, once taken,
// passes the history, group sum and window total registers before result_valid rises
// stages: input register, frame accumulate + history write, group sums, window totals,
// threshold compare into the output register
// reset clears control and frame sums; history holds no reset, only written slots are summed
// a stalled result holds its output register while bubbles ahead of it still close up

module flow_direction_gesture_detector_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fdg_pkg::ADDR_W-1:0]  paddr,
	input  logic [fdg_pkg::DATA_W-1:0]  pwdata,
	output logic [fdg_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	// flow samples
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  fdg_pkg::sample_t            sample,
	// frame results
	output logic                        result_valid,
	input  logic                        result_stall,
	output fdg_pkg::result_t            result
);

	fdg_pkg::cfg_t                   cfg;
	fdg_pkg::history_t               history;
	logic [fdg_pkg::MAX_WINDOW-1:0]  mask_s2;
	logic                            valid_s2;
	logic                            adv_s2;
	logic                            valid_s4;
	logic                            adv_s4;
	fdg_pkg::dir_total_t             totals_s4;

	// registers, effective window and registered threshold
	fdg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// per-frame sums, circular history and the window mask of the held frames
	fdg_frame_acc u_frame_acc (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.cfg          (cfg),
		.adv_s2       (adv_s2),
		.valid_s2     (valid_s2),
		.mask_s2      (mask_s2),
		.history      (history)
	);

	// two-level registered adder tree over the history
	fdg_window_sum u_window_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.history   (history),
		.mask_s2   (mask_s2),
		.valid_s2  (valid_s2),
		.adv_s2    (adv_s2),
		.adv_s4    (adv_s4),
		.valid_s4  (valid_s4),
		.totals_s4 (totals_s4)
	);

	// waving rule and output register
	fdg_decide u_decide (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s4     (valid_s4),
		.totals_s4    (totals_s4),
		.thr          (cfg.thr),
		.adv_s4       (adv_s4),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### rtl/fdg_cfg.sv
`timescale 1ns / 1ps

module fdg_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fdg_pkg::ADDR_W-1:0]  paddr,
	input  logic [fdg_pkg::DATA_W-1:0]  pwdata,
	output logic [fdg_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output fdg_pkg::cfg_t               cfg
);

	logic [fdg_pkg::WIN_CFG_W-1:0] window_q;
	logic [fdg_pkg::AREA_W-1:0]    area_q;
	logic [fdg_pkg::THR_W-1:0]     thr_q;
	logic [fdg_pkg::CNT_W-1:0]     win_eff;
	logic                          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// zero acts as one, above the history depth acts as the depth
	always_comb begin
		if (window_q == '0) begin
			win_eff = fdg_pkg::CNT_W'(1);
		end else if (int'(window_q) > fdg_pkg::MAX_WINDOW) begin
			win_eff = fdg_pkg::CNT_W'(fdg_pkg::MAX_WINDOW);
		end else begin
			win_eff = fdg_pkg::CNT_W'(window_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= fdg_pkg::WINDOW_RESET;
			area_q   <= fdg_pkg::AREA_RESET;
			thr_q    <= '0;
		end else begin
			if (wr_en) begin
				case (paddr[fdg_pkg::ADDR_W-1])
					fdg_pkg::REG_WINDOW: window_q <= pwdata[fdg_pkg::WIN_CFG_W-1:0];
					fdg_pkg::REG_AREA:   area_q   <= pwdata[fdg_pkg::AREA_W-1:0];
					default: ;
				endcase
			end
			thr_q <= fdg_pkg::THR_W'(win_eff) * fdg_pkg::THR_W'(area_q)
				* fdg_pkg::THR_W'(fdg_pkg::THR_SCALE);
		end
	end

	always_comb begin
		case (paddr[fdg_pkg::ADDR_W-1])
			fdg_pkg::REG_WINDOW: prdata = fdg_pkg::DATA_W'(window_q);
			fdg_pkg::REG_AREA:   prdata = fdg_pkg::DATA_W'(area_q);
			default:             prdata = '0;
		endcase
	end

	assign cfg.win = win_eff;
	assign cfg.thr = thr_q;

endmodule

### rtl/fdg_frame_acc.sv
`timescale 1ns / 1ps

module fdg_frame_acc (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  fdg_pkg::sample_t                sample,
	input  fdg_pkg::cfg_t                   cfg,
	input  logic                            adv_s2,
	output logic                            valid_s2,
	output logic [fdg_pkg::MAX_WINDOW-1:0]  mask_s2,
	output fdg_pkg::history_t               history
);

	logic                            valid_s1;
	fdg_pkg::sample_t                sample_s1;
	fdg_pkg::dir_frame_t             frame_q;
	fdg_pkg::dir_frame_t             frame_next;
	fdg_pkg::history_t               hist_q;
	logic [fdg_pkg::SLOT_W-1:0]      slot_q;
	logic [fdg_pkg::CNT_W-1:0]       held_q;
	logic [fdg_pkg::CNT_W-1:0]       held_next;
	logic [fdg_pkg::MAX_WINDOW-1:0]  mask_next;
	logic [fdg_pkg::MAG_W-1:0]       mag_x;
	logic [fdg_pkg::MAG_W-1:0]       mag_y;
	logic [fdg_pkg::NUM_DIR-1:0][fdg_pkg::MAG_W-1:0] addend;
	logic                            consume;
	logic                            frame_take;

	// magnitudes, most negative value gives 2^15
	assign mag_x = sample_s1.flow_dx[fdg_pkg::FLOW_W-1]
		? fdg_pkg::MAG_W'(~sample_s1.flow_dx + 1'b1) : fdg_pkg::MAG_W'(sample_s1.flow_dx);
	assign mag_y = sample_s1.flow_dy[fdg_pkg::FLOW_W-1]
		? fdg_pkg::MAG_W'(~sample_s1.flow_dy + 1'b1) : fdg_pkg::MAG_W'(sample_s1.flow_dy);

	always_comb begin
		addend = '0;
		if (sample_s1.flow_dy[fdg_pkg::FLOW_W-1]) begin
			addend[fdg_pkg::DIR_UP] = mag_y;
		end else begin
			addend[fdg_pkg::DIR_DOWN] = mag_y;
		end
		if (sample_s1.flow_dx[fdg_pkg::FLOW_W-1]) begin
			addend[fdg_pkg::DIR_LEFT] = mag_x;
		end else begin
			addend[fdg_pkg::DIR_RIGHT] = mag_x;
		end
	end

	// saturating frame sums
	always_comb begin
		logic [fdg_pkg::FRAME_W:0] s;
		for (int d = 0; d < fdg_pkg::NUM_DIR; d++) begin
			s = {1'b0, frame_q[d]} + (fdg_pkg::FRAME_W+1)'(addend[d]);
			frame_next[d] = s[fdg_pkg::FRAME_W] ? '1 : s[fdg_pkg::FRAME_W-1:0];
		end
	end

	// a frame end needs room in the window stage, other samples just accumulate
	assign consume      = valid_s1 && (!sample_s1.frame_end || adv_s2);
	assign frame_take   = consume && sample_s1.frame_end;
	assign sample_stall = valid_s1 && !consume;

	assign held_next = (held_q >= cfg.win) ? cfg.win : held_q + 1'b1;

	// entries whose age behind the newest slot is below the held count
	always_comb begin
		logic [fdg_pkg::SLOT_W:0] age;
		for (int i = 0; i < fdg_pkg::MAX_WINDOW; i++) begin
			if (slot_q >= fdg_pkg::SLOT_W'(i)) begin
				age = {1'b0, slot_q} - (fdg_pkg::SLOT_W+1)'(i);
			end else begin
				age = {1'b0, slot_q} + (fdg_pkg::SLOT_W+1)'(fdg_pkg::MAX_WINDOW - i);
			end
			mask_next[i] = age < (fdg_pkg::SLOT_W+1)'(held_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			frame_q  <= '0;
			slot_q   <= '0;
			held_q   <= '0;
		end else begin
			if (!sample_stall) begin
				valid_s1 <= sample_valid;
			end
			if (consume) begin
				frame_q <= sample_s1.frame_end ? '0 : frame_next;
			end
			if (frame_take) begin
				slot_q <= (slot_q == fdg_pkg::SLOT_W'(fdg_pkg::MAX_WINDOW - 1))
					? '0 : slot_q + 1'b1;
				held_q <= held_next;
			end
			if (adv_s2) begin
				valid_s2 <= frame_take;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
		if (frame_take) begin
			hist_q[slot_q] <= frame_next;
			mask_s2        <= mask_next;
		end
	end

	assign history = hist_q;

	a_frame_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		frame_take |=> frame_q == '0)
		else $error("frame sums not cleared after frame end");

	a_mask_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $countones(mask_s2) == int'(held_q))
		else $error("window mask does not cover the held frames");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_take |=> held_q != '0 && int'(held_q) <= fdg_pkg::MAX_WINDOW)
		else $error("held frame count out of range");

endmodule

### rtl/fdg_window_sum.sv
`timescale 1ns / 1ps

module fdg_window_sum (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fdg_pkg::history_t               history,
	input  logic [fdg_pkg::MAX_WINDOW-1:0]  mask_s2,
	input  logic                            valid_s2,
	output logic                            adv_s2,
	input  logic                            adv_s4,
	output logic                            valid_s4,
	output fdg_pkg::dir_total_t             totals_s4
);

	logic                  valid_s3;
	logic                  adv_s3;
	fdg_pkg::dir_part_t    part_next;
	fdg_pkg::dir_part_t    part_s3;
	fdg_pkg::dir_total_t   total_next;

	assign adv_s3 = !valid_s3 || adv_s4;
	assign adv_s2 = !valid_s2 || adv_s3;

	// first level: masked sums of four history entries
	always_comb begin
		logic [fdg_pkg::PART_W-1:0] acc;
		for (int d = 0; d < fdg_pkg::NUM_DIR; d++) begin
			for (int g = 0; g < fdg_pkg::N_GROUPS; g++) begin
				acc = '0;
				for (int e = 0; e < fdg_pkg::GROUP; e++) begin
					if (g * fdg_pkg::GROUP + e < fdg_pkg::MAX_WINDOW) begin
						if (mask_s2[g * fdg_pkg::GROUP + e]) begin
							acc = acc + fdg_pkg::PART_W'(history[g * fdg_pkg::GROUP + e][d]);
						end
					end
				end
				part_next[d][g] = acc;
			end
		end
	end

	// second level: group sums, saturated to the result width
	always_comb begin
		logic [fdg_pkg::FULL_W-1:0] full;
		for (int d = 0; d < fdg_pkg::NUM_DIR; d++) begin
			full = '0;
			for (int g = 0; g < fdg_pkg::N_GROUPS; g++) begin
				full = full + fdg_pkg::FULL_W'(part_s3[d][g]);
			end
			total_next[d] = (|full[fdg_pkg::FULL_W-1:fdg_pkg::TOTAL_W])
				? '1 : full[fdg_pkg::TOTAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
			if (adv_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			part_s3 <= part_next;
		end
		if (adv_s4 && valid_s3) begin
			totals_s4 <= total_next;
		end
	end

endmodule

### rtl/fdg_decide.sv
`timescale 1ns / 1ps

module fdg_decide (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid_s4,
	input  fdg_pkg::dir_total_t          totals_s4,
	input  logic [fdg_pkg::THR_W-1:0]    thr,
	output logic                         adv_s4,
	output logic                         result_valid,
	input  logic                         result_stall,
	output fdg_pkg::result_t             result
);

	logic                          adv_out;
	logic                          result_valid_q;
	fdg_pkg::result_t              result_q;
	logic [fdg_pkg::TOTAL_W-1:0]   u, d, l, r;
	logic [fdg_pkg::TOTAL_W+2:0]   lru, lrd, d5, u5;
	logic [fdg_pkg::TOTAL_W-1:0]   thr_ext;
	logic                          rel, wave;

	assign adv_out = !result_valid_q || !result_stall;
	assign adv_s4  = !valid_s4 || adv_out;

	assign u = totals_s4[fdg_pkg::DIR_UP];
	assign d = totals_s4[fdg_pkg::DIR_DOWN];
	assign l = totals_s4[fdg_pkg::DIR_LEFT];
	assign r = totals_s4[fdg_pkg::DIR_RIGHT];
	assign thr_ext = fdg_pkg::TOTAL_W'(thr);

	// relative vertical dominance and both horizontal directions above threshold
	assign lru = (fdg_pkg::TOTAL_W+3)'(l) + (fdg_pkg::TOTAL_W+3)'(r) + (fdg_pkg::TOTAL_W+3)'(u);
	assign lrd = (fdg_pkg::TOTAL_W+3)'(l) + (fdg_pkg::TOTAL_W+3)'(r) + (fdg_pkg::TOTAL_W+3)'(d);
	assign d5  = ((fdg_pkg::TOTAL_W+3)'(d) << 2) + (fdg_pkg::TOTAL_W+3)'(d);
	assign u5  = ((fdg_pkg::TOTAL_W+3)'(u) << 2) + (fdg_pkg::TOTAL_W+3)'(u);

	assign rel  = ((lru > d5) && (u > thr_ext)) || ((lrd > u5) && (d > thr_ext));
	assign wave = rel && (l > thr_ext) && (r > thr_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_out) begin
			result_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s4) begin
			result_q.waving      <= wave;
			result_q.up_total    <= u;
			result_q.down_total  <= d;
			result_q.left_total  <= l;
			result_q.right_total <= r;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_wave_needs_sides: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.waving |->
			result_q.left_total != '0 && result_q.right_total != '0)
		else $error("waving flagged without horizontal motion");

endmodule
